// File: rtl/core/cfd_pkg.sv
// Shared types, constants and CRC-8 function for the frame deframer
`timescale 1ns / 1ps

package cfd_pkg;

  // register reset values
  localparam logic [7:0] START_BYTE_RESET  = 8'hA5;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd96;

  // crc-8 parameters
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_IDLE   = 3'd0,
    EV_LEN    = 3'd1,
    EV_BYTE   = 3'd2,
    EV_GOOD   = 3'd3,
    EV_BADCRC = 3'd4,
    EV_BADLEN = 3'd5
  } event_t;

  // live configuration
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] max_payload;
  } cfg_t;

  // one result item
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data;
    logic [7:0]  position;
    logic [7:0]  payload_length;
    logic [7:0]  computed_crc;
    logic [31:0] good_frames;
    logic [31:0] dropped_frames;
  } res_t;

  // byte-wide crc-8 update, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/cfd_frame_fsm.sv
// Frame parser state machine with running crc and frame counters
`timescale 1ns / 1ps

module cfd_frame_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  cfd_pkg::cfg_t     cfg,
  output cfd_pkg::res_t     res
);

  cfd_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [31:0] good_count, good_count_next;
  logic [31:0] drop_count, drop_count_next;
  logic [7:0]  crc_upd;
  logic [7:0]  index_inc;

  // crc of the incoming byte onto the running value (init for the length byte)
  always_comb begin
    if (phase == cfd_pkg::PH_LEN) begin
      crc_upd = cfd_pkg::crc8_byte(cfd_pkg::CRC_INIT, rx_byte);
    end else begin
      crc_upd = cfd_pkg::crc8_byte(running_crc, rx_byte);
    end
  end

  assign index_inc = byte_index + 8'd1;

  // next state and result for the byte on offer
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    running_crc_next  = running_crc;
    good_count_next   = good_count;
    drop_count_next   = drop_count;
    res.event_res      = cfd_pkg::EV_IDLE;
    res.data           = rx_byte;
    res.position       = 8'd0;
    res.payload_length = 8'd0;
    res.computed_crc   = 8'd0;
    unique case (phase)
      cfd_pkg::PH_HUNT: begin
        if (rx_byte == cfg.start_byte) begin
          phase_next = cfd_pkg::PH_LEN;
        end
      end
      cfd_pkg::PH_LEN: begin
        if (rx_byte == 8'd0 || rx_byte > cfg.max_payload) begin
          drop_count_next   = drop_count + 32'd1;
          res.event_res     = cfd_pkg::EV_BADLEN;
          phase_next        = cfd_pkg::PH_HUNT;
          frame_length_next = 8'd0;
          byte_index_next   = 8'd0;
          running_crc_next  = cfd_pkg::CRC_INIT;
        end else begin
          frame_length_next  = rx_byte;
          byte_index_next    = 8'd0;
          running_crc_next   = crc_upd;
          res.event_res      = cfd_pkg::EV_LEN;
          res.payload_length = rx_byte;
          res.computed_crc   = crc_upd;
          phase_next         = cfd_pkg::PH_DATA;
        end
      end
      cfd_pkg::PH_DATA: begin
        running_crc_next   = crc_upd;
        res.event_res      = cfd_pkg::EV_BYTE;
        res.position       = byte_index;
        res.payload_length = frame_length;
        res.computed_crc   = crc_upd;
        byte_index_next    = index_inc;
        if (index_inc == frame_length) begin
          phase_next = cfd_pkg::PH_CRC;
        end
      end
      cfd_pkg::PH_CRC: begin
        res.payload_length = frame_length;
        res.computed_crc   = running_crc;
        if (running_crc == rx_byte) begin
          good_count_next = good_count + 32'd1;
          res.event_res   = cfd_pkg::EV_GOOD;
        end else begin
          drop_count_next = drop_count + 32'd1;
          res.event_res   = cfd_pkg::EV_BADCRC;
        end
        phase_next        = cfd_pkg::PH_HUNT;
        frame_length_next = 8'd0;
        byte_index_next   = 8'd0;
        running_crc_next  = cfd_pkg::CRC_INIT;
      end
      default: begin
        phase_next        = cfd_pkg::PH_HUNT;
        frame_length_next = 8'd0;
        byte_index_next   = 8'd0;
        running_crc_next  = cfd_pkg::CRC_INIT;
      end
    endcase
    res.good_frames    = good_count_next;
    res.dropped_frames = drop_count_next;
  end

  // state update once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cfd_pkg::PH_HUNT;
      frame_length <= 8'd0;
      byte_index   <= 8'd0;
      running_crc  <= cfd_pkg::CRC_INIT;
      good_count   <= 32'd0;
      drop_count   <= 32'd0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      running_crc  <= running_crc_next;
      good_count   <= good_count_next;
      drop_count   <= drop_count_next;
    end
  end

endmodule

// File: rtl/core/cfd_out_reg.sv
// Result register with valid/ready output handshake
`timescale 1ns / 1ps

module cfd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  cfd_pkg::res_t res_in,
  input  logic          out_ready,
  output logic          out_valid,
  output cfd_pkg::res_t res_out
);

  logic out_valid_next;

  // valid stays until the transfer, a load refills it
  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: rtl/core/crc8_length_frame_deframer_core.sv
// Top level of the crc-8 length-framed byte deframer
// A byte taken into the input register has its result valid once the step loads the result register.
// Throughput: one byte per cycle while out_ready holds; input register, parser step and result register.
// While a result waits, the input register still takes one byte, then the input stalls.
// Reset (rst, synchronous, active high) returns to hunting, clears counts and crc,
// and loads start byte 0xA5 and max payload 96.
`timescale 1ns / 1ps

module crc8_length_frame_deframer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      event_res,
  output logic [7:0]                      data,
  output logic [7:0]                      position,
  output logic [7:0]                      payload_length,
  output logic [7:0]                      computed_crc,
  output logic [31:0]                     good_frames,
  output logic [31:0]                     dropped_frames,
  input  logic                            cfg_we,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  cfd_pkg::cfg_t cfg;
  cfd_pkg::res_t step_res;
  cfd_pkg::res_t res_q;
  logic          s0_valid;
  logic [7:0]    s0_byte;
  logic          step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= cfd_pkg::START_BYTE_RESET;
      cfg.max_payload <= cfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfd_pkg::CFG_START_BYTE:  cfg.start_byte  <= cfg_data;
        cfd_pkg::CFG_MAX_PAYLOAD: cfg.max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: step when the result register is free or being emptied
  assign step     = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_byte <= rx_byte;
    end
  end

  cfd_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (s0_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  cfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  // result fields
  assign event_res      = res_q.event_res;
  assign data           = res_q.data;
  assign position       = res_q.position;
  assign payload_length = res_q.payload_length;
  assign computed_crc   = res_q.computed_crc;
  assign good_frames    = res_q.good_frames;
  assign dropped_frames = res_q.dropped_frames;

  // a held input byte is not overwritten before the step takes it
  a_s0_hold: assert property (@(posedge clk) disable iff (rst)
    s0_valid && !step |=> s0_valid && $stable(s0_byte))
    else $error("input byte lost while stalled");

  // payload byte index lies inside the frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == cfd_pkg::EV_BYTE |-> position < payload_length)
    else $error("payload position beyond frame length");

  // no frame context on idle or rejected length
  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == cfd_pkg::EV_IDLE || event_res == cfd_pkg::EV_BADLEN)
    |-> payload_length == 8'd0 && computed_crc == 8'd0 && position == 8'd0)
    else $error("frame fields set outside a frame");

  // a good verdict advances the good count by exactly one
  a_good_count: assert property (@(posedge clk) disable iff (rst)
    step && step_res.event_res == cfd_pkg::EV_GOOD |=> good_frames == $past(good_frames) + 32'd1
    || $past(out_valid) == 1'b0)
    else $error("good frame count did not advance");

endmodule
